@@ rtl/tbia_pkg.sv @@
`timescale 1ns / 1ps
package tbia_pkg;
    localparam int unsigned DataW = 32;
    localparam int unsigned OpW   = 5;
    localparam int unsigned DivStages = DataW;

    typedef enum logic [OpW-1:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_DIV  = 5'd3,
        OP_MOD  = 5'd4,
        OP_SHL  = 5'd5,
        OP_SHR  = 5'd6,
        OP_LT   = 5'd7,
        OP_GT   = 5'd8,
        OP_LE   = 5'd9,
        OP_GE   = 5'd10,
        OP_EQ   = 5'd11,
        OP_NE   = 5'd12,
        OP_AND  = 5'd13,
        OP_OR   = 5'd14,
        OP_XOR  = 5'd15,
        OP_LAND = 5'd16,
        OP_LOR  = 5'd17,
        OP_NEG  = 5'd18,
        OP_LNOT = 5'd19
    } t_opcode;

    typedef struct packed {
        logic [OpW-1:0]   opcode;
        logic             type_a;
        logic             type_b;
        logic [DataW-1:0] operand_a;
        logic [DataW-1:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic [DataW-1:0] result_value;
        logic             result_type;
        logic             status;
    } t_out_word;

    // Per-item control carried alongside the divider stages.
    typedef struct packed {
        logic             is_div;
        logic             want_rem;
        logic             neg_q;
        logic             neg_r;
        logic [DataW-1:0] val;
        logic             rtype;
        logic             status;
    } t_ctl;
endpackage

@@ rtl/tbia_if.sv @@
`timescale 1ns / 1ps
interface tbia_in_if;
    logic              valid;
    logic              ready;
    tbia_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tbia_out_if;
    logic               valid;
    logic               ready;
    tbia_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/typed_byte_int_alu_top.sv @@
`timescale 1ns / 1ps
// Typed byte/int ALU for a virtual machine.
// Input channel i_in (tbia_in_if sink) carries one instruction word: opcode, operand
// types and two 32-bit operands. Output channel o_out (tbia_out_if source) carries
// result_value, result_type and status (1 on divide or mod by zero).
// A word is moved at a rising edge with valid and ready both high.
// Throughput: one word per cycle while o_out is not stalled. The pipeline holds
// a decode stage, a multiply and divider setup stage, the restoring divider,
// which resolves one quotient bit per stage over 32 stages, and an
// output stage that fixes signs and wraps bytes. Every opcode travels the same
// pipeline, so order holds.
// The whole pipeline advances only when the output register is empty or being
// taken; when the receiver stalls, every stage holds and i_in.ready drops, and
// nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; payloads are not reset.
module typed_byte_int_alu_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbia_in_if.sink    i_in,
    tbia_out_if.source o_out
);
    localparam int unsigned W = tbia_pkg::DataW;
    localparam int unsigned N = tbia_pkg::DivStages;

    logic adv;
    assign adv = !o_out.valid || o_out.ready;
    assign i_in.ready = adv;

    // Stage 1: read operands, compute all but mul/div.
    logic [W-1:0] a, b;
    logic         ta, tb;
    assign ta = i_in.data.type_a;
    assign tb = i_in.data.type_b;
    assign a  = ta ? i_in.data.operand_a : {{(W-8){1'b0}}, i_in.data.operand_a[7:0]};
    assign b  = tb ? i_in.data.operand_b : {{(W-8){1'b0}}, i_in.data.operand_b[7:0]};

    logic         lt, gt;
    logic         big_amt;
    logic [W-1:0] shr_v;
    tbia_pkg::t_ctl n_c1;
    logic           n_mul;
    assign lt = $signed(a) < $signed(b);
    assign gt = $signed(b) < $signed(a);
    assign big_amt = b[W-1] || (b[W-2:0] >= (W-1)'(W));
    assign shr_v = big_amt ? {W{a[W-1]}} : W'($signed(a) >>> b[4:0]);

    always_comb begin
        n_c1 = '0;
        n_c1.rtype = ta | tb;
        n_mul = 1'b0;
        case (i_in.data.opcode)
            tbia_pkg::OP_ADD:  n_c1.val = a + b;
            tbia_pkg::OP_SUB:  n_c1.val = a - b;
            tbia_pkg::OP_MUL:  n_mul = 1'b1;
            tbia_pkg::OP_DIV, tbia_pkg::OP_MOD: begin
                if (b == '0) begin
                    n_c1.status = 1'b1;
                    n_c1.rtype  = 1'b0;
                end else begin
                    n_c1.is_div   = 1'b1;
                    n_c1.want_rem = (i_in.data.opcode == tbia_pkg::OP_MOD);
                    n_c1.neg_q    = a[W-1] ^ b[W-1];
                    n_c1.neg_r    = a[W-1];
                end
            end
            tbia_pkg::OP_SHL:  n_c1.val = big_amt ? '0 : (a << b[4:0]);
            tbia_pkg::OP_SHR:  n_c1.val = shr_v;
            tbia_pkg::OP_LT:   begin n_c1.val = W'(lt);  n_c1.rtype = 1'b0; end
            tbia_pkg::OP_GT:   begin n_c1.val = W'(gt);  n_c1.rtype = 1'b0; end
            tbia_pkg::OP_LE:   begin n_c1.val = W'(!gt); n_c1.rtype = 1'b0; end
            tbia_pkg::OP_GE:   begin n_c1.val = W'(!lt); n_c1.rtype = 1'b0; end
            tbia_pkg::OP_EQ:   begin n_c1.val = W'(a == b); n_c1.rtype = 1'b0; end
            tbia_pkg::OP_NE:   begin n_c1.val = W'(a != b); n_c1.rtype = 1'b0; end
            tbia_pkg::OP_AND:  n_c1.val = a & b;
            tbia_pkg::OP_OR:   n_c1.val = a | b;
            tbia_pkg::OP_XOR:  n_c1.val = a ^ b;
            tbia_pkg::OP_LAND: begin
                n_c1.val = W'((a != '0) && (b != '0)); n_c1.rtype = 1'b0;
            end
            tbia_pkg::OP_LOR:  begin
                n_c1.val = W'((a != '0) || (b != '0)); n_c1.rtype = 1'b0;
            end
            tbia_pkg::OP_NEG:  begin n_c1.val = '0 - a; n_c1.rtype = ta; end
            tbia_pkg::OP_LNOT: begin n_c1.val = W'(a == '0); n_c1.rtype = ta; end
            default:           n_c1.rtype = 1'b0;
        endcase
    end

    logic           r_v1;
    tbia_pkg::t_ctl r_c1;
    logic           r_mul1;
    logic [W-1:0]   r_a1, r_b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (adv) r_v1 <= i_in.valid;
        if (adv) begin
            r_c1 <= n_c1; r_mul1 <= n_mul; r_a1 <= a; r_b1 <= b;
        end
    end

    // Stage 2: multiply, and take divider operand magnitudes.
    logic           r_v2;
    tbia_pkg::t_ctl r_c2;
    tbia_pkg::t_ctl n_c2;
    logic [W-1:0]   r_ua2, r_ub2;
    always_comb begin
        n_c2 = r_c1;
        if (r_mul1) n_c2.val = W'(r_a1 * r_b1);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (adv) r_v2 <= r_v1;
        if (adv) begin
            r_c2 <= n_c2;
            r_ua2 <= r_a1[W-1] ? '0 - r_a1 : r_a1;
            r_ub2 <= r_b1[W-1] ? '0 - r_b1 : r_b1;
        end
    end

    // Divider: one restoring step per stage.
    logic           r_dv  [N];
    tbia_pkg::t_ctl r_dc  [N];
    logic [W-1:0]   r_dq  [N];
    logic [W-1:0]   r_dr  [N];
    logic [W-1:0]   r_dd  [N];
    logic           dv_in [N];
    tbia_pkg::t_ctl dc_in [N];
    logic [W-1:0]   dq_in [N];
    logic [W-1:0]   dr_in [N];
    logic [W-1:0]   dd_in [N];
    logic [W-1:0]   dn_q  [N];
    logic [W-1:0]   dn_r  [N];

    for (genvar k = 0; k < N; k++) begin : g_div
        logic [W:0] trial;
        if (k == 0) begin : g_first
            assign dv_in[k] = r_v2;
            assign dc_in[k] = r_c2;
            assign dq_in[k] = r_ua2;
            assign dr_in[k] = '0;
            assign dd_in[k] = r_ub2;
        end else begin : g_next
            assign dv_in[k] = r_dv[k-1];
            assign dc_in[k] = r_dc[k-1];
            assign dq_in[k] = r_dq[k-1];
            assign dr_in[k] = r_dr[k-1];
            assign dd_in[k] = r_dd[k-1];
        end
        assign trial = {dr_in[k], dq_in[k][W-1]} - {1'b0, dd_in[k]};
        assign dn_r[k] = trial[W] ? {dr_in[k][W-2:0], dq_in[k][W-1]} : trial[W-1:0];
        assign dn_q[k] = {dq_in[k][W-2:0], !trial[W]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[k] <= 1'b0;
            else if (adv) r_dv[k] <= dv_in[k];
            if (adv) begin
                r_dc[k] <= dc_in[k];
                r_dq[k] <= dn_q[k];
                r_dr[k] <= dn_r[k];
                r_dd[k] <= dd_in[k];
            end
        end
    end

    // Final stage: signs, byte wrap.
    tbia_pkg::t_ctl  fc;
    logic [W-1:0]    fv;
    tbia_pkg::t_out_word n_out;
    assign fc = r_dc[N-1];
    always_comb begin
        fv = fc.val;
        if (fc.is_div) begin
            if (fc.want_rem) fv = fc.neg_r ? '0 - r_dr[N-1] : r_dr[N-1];
            else             fv = fc.neg_q ? '0 - r_dq[N-1] : r_dq[N-1];
        end
        n_out.result_value = fc.rtype ? fv : {{(W-8){1'b0}}, fv[7:0]};
        n_out.result_type  = fc.rtype;
        n_out.status       = fc.status;
    end

    logic                r_ov;
    tbia_pkg::t_out_word r_od;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_dv[N-1];
        if (adv) r_od <= n_out;
    end
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;
endmodule

@@ rtl/tbia_checker.sv @@
`timescale 1ns / 1ps
module tbia_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input tbia_pkg::t_out_word out_data
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed under stall");
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");
    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.result_type |-> out_data.result_value[31:8] == '0)
        else $error("byte result out of range");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.status |-> out_data.result_value == '0 && !out_data.result_type)
        else $error("error word not zero");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("valid after reset");
endmodule

bind typed_byte_int_alu_top tbia_checker u_tbia_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (i_in.valid),
    .in_ready (i_in.ready),
    .out_valid(o_out.valid),
    .out_ready(o_out.ready),
    .out_data (o_out.data)
);
